// ----- src/tagged_message_match_table_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the tagged message match table
// Shared helpers for concurrent checks with synchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef TAGGED_MESSAGE_MATCH_TABLE_MACROS_SVH
`define TAGGED_MESSAGE_MATCH_TABLE_MACROS_SVH

// A condition that holds at every clock edge outside reset.
`define TMMT_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// An antecedent that implies a consequent in the same cycle.
`define TMMT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

// ----- src/tmmt_pkg.sv -----
// ----------------------------------------------------------------------------
// tmmt_pkg
// Types and constants shared by the match table modules.
// ----------------------------------------------------------------------------
package tmmt_pkg;

    localparam int DEF_TABLE_DEPTH  = 64;
    localparam int DEF_CONTEXT_BITS = 16;

    // Register indexes of the configuration port.
    localparam logic REG_POSTED_MODE = 1'b0;
    localparam logic REG_SRC_MATCH   = 1'b1;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_MATCH  = 2'd1,
        OP_REMOVE = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_NOMATCH = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALLOC,
        S_READ,
        S_EVAL,
        S_FINISH
    } t_state;

    // Fixed-width part of one table entry.
    typedef struct packed {
        logic [63:0] tag;
        logic [63:0] mask;
        logic [63:0] addr;
        logic        addr_any;
        logic [15:0] handle;
    } t_slot;

    // Controls of the free slot map.
    typedef struct packed {
        logic start;
        logic step;
        logic take;
        logic release_slot;
    } t_free_ctrl;

endpackage

// ----- src/tagged_message_match_table.sv -----
// ----------------------------------------------------------------------------
// tagged_message_match_table
// Ordered table of pending message requests with tag matching.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the input channel (i_in_valid / o_in_stall) and each
//   gives one result (o_out_valid / i_out_stall) with a status and handle.
//   The table is a linked list kept in the entry and link memories; a match
//   or removal walks it from the head, with a memory read (S_READ) and then
//   a compare (S_EVAL) per entry visited, since the next link comes out of
//   the read itself. Insert scans the free map one slot per cycle for a free
//   slot. One request is worked on at a time; a new one is taken as soon as
//   the previous result sits in the output register. Reset empties the
//   table and clears both configuration registers; no memory clearing is
//   needed. While the receiver stalls, the result holds and a finished
//   request waits until the output register frees.
//   The user must write the configuration through the APB port only while
//   the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`include "tagged_message_match_table_macros.svh"

module tagged_message_match_table #(
    parameter int TABLE_DEPTH  = tmmt_pkg::DEF_TABLE_DEPTH,
    parameter int CONTEXT_BITS = tmmt_pkg::DEF_CONTEXT_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_operation,
    input  logic [63:0] i_tag,
    input  logic [63:0] i_ignore_mask,
    input  logic        i_peek_flag,
    input  logic        i_claim_flag,
    input  logic        i_discard_flag,
    input  logic [15:0] i_context_id,
    input  logic [63:0] i_source_address,
    input  logic        i_address_any,
    input  logic [15:0] i_request_handle,
    input  logic [15:0] i_owner_context,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [15:0] o_found_handle
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    tmmt_pkg::t_state r_state, n_state;

    // Configuration registers.
    logic r_posted, r_src_match;

    // Latched request.
    logic [1:0]              r_op;
    logic [63:0]             r_tag, r_qmask, r_addr;
    logic                    r_peek, r_claim, r_discard, r_any;
    logic [CONTEXT_BITS-1:0] r_ctx, r_owner;
    logic [15:0]             r_handle;

    // List state and walk registers.
    logic [IW-1:0] r_head, n_head, r_tail, n_tail;
    logic [CW-1:0] r_count, n_count;
    logic [IW-1:0] r_cur, n_cur, r_prev, n_prev;
    logic          r_has_prev, n_has_prev;
    logic [CW-1:0] r_n, n_n;
    tmmt_pkg::t_status r_res_status, n_res_status;
    logic [15:0]   r_res_handle, n_res_handle;

    // Output register.
    logic          r_out_valid, n_out_valid;
    logic [1:0]    r_out_status, n_out_status;
    logic [15:0]   r_out_handle, n_out_handle;

    // Memory and free map connections.
    logic                    w_wr_en, w_nxt_wr_en;
    logic [IW-1:0]           w_wr_addr, w_nxt_wr_addr, w_nxt_wr_data;
    tmmt_pkg::t_slot         w_wr_slot, w_rd_slot;
    logic [CONTEXT_BITS-1:0] w_wr_claim, w_wr_owner, w_rd_claim, w_rd_owner;
    logic [IW-1:0]           w_rd_next;
    tmmt_pkg::t_free_ctrl    w_free_ctrl;
    logic                    w_free_hit;
    logic [IW-1:0]           w_free_idx;

    logic w_accept, w_cfg_wr, w_hit, w_fit_claim, w_fit_addr, w_fit_tag, w_keep;
    logic [63:0] w_mask;

    assign pready     = 1'b1;
    assign w_cfg_wr   = psel & penable & pwrite & pready;
    assign o_in_stall = (r_state != tmmt_pkg::S_IDLE);
    assign w_accept   = i_in_valid & ~o_in_stall;

    // Configuration write and read back.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_posted    <= 1'b0;
            r_src_match <= 1'b0;
        end else if (w_cfg_wr) begin
            unique case (paddr[2])
                tmmt_pkg::REG_POSTED_MODE: r_posted    <= pwdata[0];
                tmmt_pkg::REG_SRC_MATCH:   r_src_match <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            tmmt_pkg::REG_POSTED_MODE: prdata = {31'd0, r_posted};
            tmmt_pkg::REG_SRC_MATCH:   prdata = {31'd0, r_src_match};
            default:                   prdata = '0;
        endcase
    end

    // Request capture on acceptance.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op      <= i_operation;
            r_tag     <= i_tag;
            r_qmask   <= i_ignore_mask;
            r_peek    <= i_peek_flag;
            r_claim   <= i_claim_flag;
            r_discard <= i_discard_flag;
            r_ctx     <= CONTEXT_BITS'(i_context_id);
            r_addr    <= i_source_address;
            r_any     <= i_address_any;
            r_handle  <= i_request_handle;
            r_owner   <= CONTEXT_BITS'(i_owner_context);
        end
    end

    // Entry fit test on the entry just read.
    always_comb begin
        if (r_claim && r_peek) begin
            w_fit_claim = (r_ctx != '0) && (r_ctx != w_rd_claim);
        end else if (r_claim) begin
            w_fit_claim = (w_rd_claim != '0) && (r_ctx == w_rd_claim);
        end else begin
            w_fit_claim = (w_rd_claim == '0);
        end
        w_fit_addr = !r_src_match || (r_posted ? w_rd_slot.addr_any : r_any)
                     || (w_rd_slot.addr == r_addr);
        w_mask     = r_posted ? w_rd_slot.mask : r_qmask;
        w_fit_tag  = ((w_rd_slot.tag ^ r_tag) & ~w_mask) == 64'd0;
        if (r_op == tmmt_pkg::OP_MATCH) begin
            w_hit = w_fit_claim && w_fit_addr && w_fit_tag;
        end else begin
            w_hit = (w_rd_owner == r_ctx);
        end
        w_keep = (r_op == tmmt_pkg::OP_MATCH) && r_peek && !r_discard;
    end

    // State and list registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tmmt_pkg::S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur        <= n_cur;
        r_prev       <= n_prev;
        r_has_prev   <= n_has_prev;
        r_n          <= n_n;
        r_res_status <= n_res_status;
        r_res_handle <= n_res_handle;
        r_out_status <= n_out_status;
        r_out_handle <= n_out_handle;
    end

    // Sequencer: next state, list updates and memory accesses.
    always_comb begin
        n_state       = r_state;
        n_head        = r_head;
        n_tail        = r_tail;
        n_count       = r_count;
        n_cur         = r_cur;
        n_prev        = r_prev;
        n_has_prev    = r_has_prev;
        n_n           = r_n;
        n_res_status  = r_res_status;
        n_res_handle  = r_res_handle;
        n_out_valid   = r_out_valid & i_out_stall;
        n_out_status  = r_out_status;
        n_out_handle  = r_out_handle;
        w_wr_en       = 1'b0;
        w_wr_addr     = r_cur;
        w_wr_slot     = w_rd_slot;
        w_wr_claim    = w_rd_claim;
        w_wr_owner    = w_rd_owner;
        w_nxt_wr_en   = 1'b0;
        w_nxt_wr_addr = r_prev;
        w_nxt_wr_data = w_rd_next;
        w_free_ctrl   = '0;

        unique case (r_state)
            tmmt_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_res_handle = '0;
                    n_cur        = r_head;
                    n_prev       = '0;
                    n_has_prev   = 1'b0;
                    n_n          = '0;
                    case (i_operation) inside
                        tmmt_pkg::OP_INSERT: begin
                            if (r_count >= CW'(TABLE_DEPTH)) begin
                                n_res_status = tmmt_pkg::ST_FULL;
                                n_state      = tmmt_pkg::S_FINISH;
                            end else begin
                                w_free_ctrl.start = 1'b1;
                                n_state           = tmmt_pkg::S_ALLOC;
                            end
                        end
                        tmmt_pkg::OP_MATCH, tmmt_pkg::OP_REMOVE: begin
                            n_res_status = tmmt_pkg::ST_NOMATCH;
                            n_state = (r_count == '0) ? tmmt_pkg::S_FINISH
                                                      : tmmt_pkg::S_READ;
                        end
                        default: begin
                            n_res_status = tmmt_pkg::ST_NOMATCH;
                            n_state      = tmmt_pkg::S_FINISH;
                        end
                    endcase
                end
            end
            tmmt_pkg::S_ALLOC: begin
                if (w_free_hit) begin
                    w_free_ctrl.take   = 1'b1;
                    w_wr_en            = 1'b1;
                    w_wr_addr          = w_free_idx;
                    w_wr_slot.tag      = r_tag;
                    w_wr_slot.mask     = r_posted ? r_qmask : 64'd0;
                    w_wr_slot.addr     = r_addr;
                    w_wr_slot.addr_any = r_any;
                    w_wr_slot.handle   = r_handle;
                    w_wr_claim         = '0;
                    w_wr_owner         = r_owner;
                    w_nxt_wr_en        = (r_count != '0);
                    w_nxt_wr_addr      = r_tail;
                    w_nxt_wr_data      = w_free_idx;
                    if (r_count == '0) begin
                        n_head = w_free_idx;
                    end
                    n_tail       = w_free_idx;
                    n_count      = r_count + CW'(1);
                    n_res_status = tmmt_pkg::ST_DONE;
                    n_state      = tmmt_pkg::S_FINISH;
                end else begin
                    w_free_ctrl.step = 1'b1;
                end
            end
            tmmt_pkg::S_READ: begin
                n_state = tmmt_pkg::S_EVAL;
            end
            tmmt_pkg::S_EVAL: begin
                if (w_hit) begin
                    n_res_status = tmmt_pkg::ST_DONE;
                    n_res_handle = w_rd_slot.handle;
                    n_state      = tmmt_pkg::S_FINISH;
                    if (w_keep) begin
                        // Peek: a claiming request writes the entry back with the new claim.
                        w_wr_en    = r_claim;
                        w_wr_claim = r_ctx;
                    end else begin
                        // Unlink the entry and return its slot.
                        w_nxt_wr_en              = r_has_prev;
                        w_free_ctrl.release_slot = 1'b1;
                        if (r_has_prev) begin
                            if (r_tail == r_cur) begin
                                n_tail = r_prev;
                            end
                        end else begin
                            n_head = w_rd_next;
                            if (r_tail == r_cur) begin
                                n_tail = '0;
                            end
                        end
                        if (r_count == CW'(1)) begin
                            n_head = '0;
                            n_tail = '0;
                        end
                        n_count = r_count - CW'(1);
                    end
                end else if (r_n + CW'(1) == r_count) begin
                    n_state = tmmt_pkg::S_FINISH;
                end else begin
                    n_n        = r_n + CW'(1);
                    n_prev     = r_cur;
                    n_has_prev = 1'b1;
                    n_cur      = w_rd_next;
                    n_state    = tmmt_pkg::S_READ;
                end
            end
            tmmt_pkg::S_FINISH: begin
                if (!(r_out_valid && i_out_stall)) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_handle = r_res_handle;
                    n_state      = tmmt_pkg::S_IDLE;
                end
            end
            default: n_state = tmmt_pkg::S_IDLE;
        endcase
    end

    tmmt_slot_mem #(
        .TABLE_DEPTH  (TABLE_DEPTH),
        .CONTEXT_BITS (CONTEXT_BITS)
    ) u_slot_mem (
        .i_clk         (i_clk),
        .i_wr_en       (w_wr_en),
        .i_wr_addr     (w_wr_addr),
        .i_wr_slot     (w_wr_slot),
        .i_wr_claim    (w_wr_claim),
        .i_wr_owner    (w_wr_owner),
        .i_nxt_wr_en   (w_nxt_wr_en),
        .i_nxt_wr_addr (w_nxt_wr_addr),
        .i_nxt_wr_data (w_nxt_wr_data),
        .i_rd_addr     (r_cur),
        .o_rd_slot     (w_rd_slot),
        .o_rd_claim    (w_rd_claim),
        .o_rd_owner    (w_rd_owner),
        .o_rd_next     (w_rd_next)
    );

    tmmt_free_map #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_free_map (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (w_free_ctrl),
        .i_rel_idx (r_cur),
        .o_hit     (w_free_hit),
        .o_idx     (w_free_idx)
    );

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_found_handle = r_out_handle;

    // The entry count never passes the table depth.
    `TMMT_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CW'(TABLE_DEPTH))
    // The walk never visits more entries than the list holds.
    `TMMT_ASSERT_IMPL(a_walk_bound, i_clk, i_rst_n, r_state == tmmt_pkg::S_EVAL, r_n < r_count)
    // An allocation only starts with room in the table.
    `TMMT_ASSERT_IMPL(a_alloc_room, i_clk, i_rst_n, r_state == tmmt_pkg::S_ALLOC, r_count < CW'(TABLE_DEPTH))
    // A finished result never overwrites one still waiting.
    `TMMT_ASSERT_IMPL(a_no_overwrite, i_clk, i_rst_n, r_out_valid && i_out_stall, n_out_valid && (n_out_handle == r_out_handle))

endmodule

// ----- src/tmmt_slot_mem.sv -----
// ----------------------------------------------------------------------------
// tmmt_slot_mem
// Entry memory and next-link memory, with registered synchronous reads.
// ----------------------------------------------------------------------------
module tmmt_slot_mem #(
    parameter int TABLE_DEPTH  = tmmt_pkg::DEF_TABLE_DEPTH,
    parameter int CONTEXT_BITS = tmmt_pkg::DEF_CONTEXT_BITS,
    localparam int IW = $clog2(TABLE_DEPTH)
) (
    input  logic                    i_clk,
    input  logic                    i_wr_en,
    input  logic [IW-1:0]           i_wr_addr,
    input  tmmt_pkg::t_slot         i_wr_slot,
    input  logic [CONTEXT_BITS-1:0] i_wr_claim,
    input  logic [CONTEXT_BITS-1:0] i_wr_owner,
    input  logic                    i_nxt_wr_en,
    input  logic [IW-1:0]           i_nxt_wr_addr,
    input  logic [IW-1:0]           i_nxt_wr_data,
    input  logic [IW-1:0]           i_rd_addr,
    output tmmt_pkg::t_slot         o_rd_slot,
    output logic [CONTEXT_BITS-1:0] o_rd_claim,
    output logic [CONTEXT_BITS-1:0] o_rd_owner,
    output logic [IW-1:0]           o_rd_next
);

    localparam int WW = $bits(tmmt_pkg::t_slot) + 2 * CONTEXT_BITS;

    logic [WW-1:0] r_mem [TABLE_DEPTH];
    logic [IW-1:0] r_nxt [TABLE_DEPTH];
    logic [WW-1:0] r_rd_word;
    logic [IW-1:0] r_rd_next;

    // Entry memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= {i_wr_slot, i_wr_claim, i_wr_owner};
        end
        r_rd_word <= r_mem[i_rd_addr];
    end

    // Link memory, read at the same address as the entry.
    always_ff @(posedge i_clk) begin
        if (i_nxt_wr_en) begin
            r_nxt[i_nxt_wr_addr] <= i_nxt_wr_data;
        end
        r_rd_next <= r_nxt[i_rd_addr];
    end

    assign o_rd_slot  = r_rd_word[WW-1 -: $bits(tmmt_pkg::t_slot)];
    assign o_rd_claim = r_rd_word[2*CONTEXT_BITS-1 -: CONTEXT_BITS];
    assign o_rd_owner = r_rd_word[CONTEXT_BITS-1:0];
    assign o_rd_next  = r_rd_next;

endmodule

// ----- src/tmmt_free_map.sv -----
// ----------------------------------------------------------------------------
// tmmt_free_map
// Free bit per slot and a scan pointer that finds a free slot.
// ----------------------------------------------------------------------------
module tmmt_free_map #(
    parameter int TABLE_DEPTH = tmmt_pkg::DEF_TABLE_DEPTH,
    localparam int IW = $clog2(TABLE_DEPTH)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tmmt_pkg::t_free_ctrl i_ctrl,
    input  logic [IW-1:0]        i_rel_idx,
    output logic                 o_hit,
    output logic [IW-1:0]        o_idx
);

    logic [TABLE_DEPTH-1:0] r_free;
    logic [IW-1:0]          r_scan;

    // Free bits: all slots free after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free <= '1;
        end else begin
            if (i_ctrl.take) begin
                r_free[r_scan] <= 1'b0;
            end
            if (i_ctrl.release_slot) begin
                r_free[i_rel_idx] <= 1'b1;
            end
        end
    end

    // The scan restarts at slot zero on start and steps one slot per cycle while step is set.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan <= '0;
        end else if (i_ctrl.start) begin
            r_scan <= '0;
        end else if (i_ctrl.step) begin
            r_scan <= r_scan + IW'(1);
        end
    end

    assign o_hit = r_free[r_scan];
    assign o_idx = r_scan;

endmodule
